[hdl/nosc_pkg.sv]
package nosc_pkg;

	// signed order code: -1, 0, +1
	typedef logic signed [1:0] order_t;

	localparam order_t ORD_LT = 2'sb11;
	localparam order_t ORD_EQ = 2'sb00;
	localparam order_t ORD_GT = 2'sb01;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7a;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// compare sequencer states
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PRIME = 5'b00010,
		S_ZERO  = 5'b00100,
		S_DIGIT = 5'b01000,
		S_PLAIN = 5'b10000
	} state_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [7:0] upper_ascii(input logic [7:0] c);
		if ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) begin
			return c - CASE_OFS;
		end
		return c;
	endfunction

	// unsigned byte compare reduced to its sign
	function automatic order_t cmp_byte(input logic [7:0] x, input logic [7:0] y);
		if (x < y) begin
			return ORD_LT;
		end
		if (x > y) begin
			return ORD_GT;
		end
		return ORD_EQ;
	endfunction

endpackage

[hdl/natural_order_string_compare.sv]
// Channel   Signals                                        Handshake
// input     a_byte a_valid b_byte b_valid last             start & !busy
// result    order too_long                                 done, one cycle
//
// Loading accepts one transaction per cycle while busy is low. After the transaction
// marked last the sequencer walks both stores through the registered read port, and
// when both strings end together it runs the plain byte compare from the start. No new
// transaction is taken while busy, which is high for the whole walk.
// Reset clears the lengths, the overflow flag and the sequencer; the stores are not
// cleared. done cannot be held off by the receiver.
module natural_order_string_compare
	import nosc_pkg::*;
#(
	parameter int MAX_LEN = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] a_byte,
	input  logic       a_valid,
	input  logic [7:0] b_byte,
	input  logic       b_valid,
	input  logic       last,
	output logic       done,
	output order_t     order,
	output logic       too_long
);

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);

	state_t      state_q, state_d;
	logic [LW-1:0] len_a_q, len_b_q;
	logic        ovf_q;
	logic [LW-1:0] pa_q, pa_d, pb_q, pb_d;
	logic [LW-1:0] za_q, za_d, zb_q, zb_d;
	order_t      diff_q, diff_d;
	logic        done_q;
	order_t      order_q;
	logic        too_long_q;

	logic        accept;
	logic        we_a, we_b;
	logic [7:0]  cur_a, cur_b;
	logic        av, bv, ad, bd;
	logic [7:0]  ua, ub;
	logic        fin;
	order_t      fin_ord;

	assign accept = start && (state_q == S_IDLE);
	assign we_a   = accept && a_valid && (len_a_q < MAX_L);
	assign we_b   = accept && b_valid && (len_b_q < MAX_L);

	nosc_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (len_a_q[AW-1:0]),
		.wdata (a_byte),
		.raddr (pa_d[AW-1:0]),
		.rdata (cur_a)
	);

	nosc_store #(.DEPTH(MAX_LEN), .AW(AW)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (len_b_q[AW-1:0]),
		.wdata (b_byte),
		.raddr (pb_d[AW-1:0]),
		.rdata (cur_b)
	);

	// character classes at the current positions
	assign av = pa_q < len_a_q;
	assign bv = pb_q < len_b_q;
	assign ad = av && is_digit(cur_a);
	assign bd = bv && is_digit(cur_b);
	assign ua = upper_ascii(cur_a);
	assign ub = upper_ascii(cur_b);

	// walk sequencer
	always_comb begin
		state_d = state_q;
		pa_d    = pa_q;
		pb_d    = pb_q;
		za_d    = za_q;
		zb_d    = zb_q;
		diff_d  = diff_q;
		fin     = 1'b0;
		fin_ord = ORD_EQ;
		unique case (state_q)
			S_IDLE: begin
				if (accept && last) begin
					state_d = S_PRIME;
					pa_d    = '0;
					pb_d    = '0;
				end
			end
			S_PRIME: begin
				// reissue address zero after the last write
				state_d = S_ZERO;
				za_d    = '0;
				zb_d    = '0;
			end
			S_ZERO: begin
				// skip leading zeros on both sides at once
				if (av && (cur_a == CH_ZERO)) begin
					pa_d = pa_q + 1'b1;
					za_d = za_q + 1'b1;
				end
				if (bv && (cur_b == CH_ZERO)) begin
					pb_d = pb_q + 1'b1;
					zb_d = zb_q + 1'b1;
				end
				if (!(av && (cur_a == CH_ZERO)) && !(bv && (cur_b == CH_ZERO))) begin
					state_d = S_DIGIT;
					diff_d  = ORD_EQ;
				end
			end
			S_DIGIT: begin
				// digit runs in lockstep; a run ending first is the shorter one
				priority if (ad && bd) begin
					if ((diff_q == ORD_EQ) && (cur_a != cur_b)) begin
						diff_d = cmp_byte(cur_a, cur_b);
					end
					pa_d = pa_q + 1'b1;
					pb_d = pb_q + 1'b1;
				end else if (ad) begin
					fin     = 1'b1;
					fin_ord = ORD_GT;
				end else if (bd) begin
					fin     = 1'b1;
					fin_ord = ORD_LT;
				end else if (diff_q != ORD_EQ) begin
					fin     = 1'b1;
					fin_ord = diff_q;
				end else if (za_q != zb_q) begin
					fin     = 1'b1;
					fin_ord = (za_q > zb_q) ? ORD_LT : ORD_GT;
				end else if (!av) begin
					if (!bv) begin
						state_d = S_PLAIN;
						pa_d    = '0;
						pb_d    = '0;
					end else begin
						fin     = 1'b1;
						fin_ord = ORD_LT;
					end
				end else if (!bv) begin
					fin     = 1'b1;
					fin_ord = ORD_GT;
				end else if (ua != ub) begin
					fin     = 1'b1;
					fin_ord = cmp_byte(ua, ub);
				end else begin
					pa_d    = pa_q + 1'b1;
					pb_d    = pb_q + 1'b1;
					za_d    = '0;
					zb_d    = '0;
					state_d = S_ZERO;
				end
			end
			S_PLAIN: begin
				// case-sensitive byte compare, then lengths
				if (av && bv) begin
					if (cur_a != cur_b) begin
						fin     = 1'b1;
						fin_ord = cmp_byte(cur_a, cur_b);
					end else begin
						pa_d = pa_q + 1'b1;
						pb_d = pb_q + 1'b1;
					end
				end else begin
					fin     = 1'b1;
					fin_ord = (len_a_q < len_b_q) ? ORD_LT :
						((len_a_q > len_b_q) ? ORD_GT : ORD_EQ);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_a_q <= '0;
			len_b_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (fin) begin
				len_a_q <= '0;
				len_b_q <= '0;
				ovf_q   <= 1'b0;
			end else if (accept) begin
				if (we_a) begin
					len_a_q <= len_a_q + 1'b1;
				end
				if (we_b) begin
					len_b_q <= len_b_q + 1'b1;
				end
				if ((a_valid && !we_a) || (b_valid && !we_b)) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// walk pointers, counters and result payload
	always_ff @(posedge clk) begin
		pa_q   <= pa_d;
		pb_q   <= pb_d;
		za_q   <= za_d;
		zb_q   <= zb_d;
		diff_q <= diff_d;
		if (fin) begin
			order_q    <= fin_ord;
			too_long_q <= ovf_q;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign order    = order_q;
	assign too_long = too_long_q;

endmodule

[hdl/nosc_store.sv]
// Character store: one write port, one read port, registered read data
module nosc_store
	import nosc_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
